[hw/rtl/cisp_pkg.sv]
// Shared codes and controller-to-datapath types for the cubic sample player.
package cisp_pkg;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_TRIGGER = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [1:0] CFG_LOOP   = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BASE   = 2'd2;

  localparam logic [1:0] NBR_PREV  = 2'd0;
  localparam logic [1:0] NBR_HERE  = 2'd1;
  localparam logic [1:0] NBR_NEXT  = 2'd2;
  localparam logic [1:0] NBR_AFTER = 2'd3;

  localparam logic [1:0] HSTEP_A1 = 2'd0;
  localparam logic [1:0] HSTEP_A2 = 2'd1;
  localparam logic [1:0] HSTEP_A3 = 2'd2;

  localparam int FIELD_BITS  = 24;
  localparam int LENGTH_BITS = 17;
  localparam int INDEX_BITS  = 16;

  typedef struct packed {
    logic       load_sample;
    logic       trigger;
    logic       div_init;
    logic       div_step;
    logic       nbr_calc;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       coef;
    logic       mul;
    logic       acc_add;
    logic [1:0] add_sel;
    logic       finish;
    logic       stop_tick;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic out_full;
  } status_t;

endpackage

[hw/rtl/cisp_if.sv]
// Handshake channels for input items and result items.
interface cisp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] load_index;
  logic signed [23:0] load_value;
  logic [23:0] frequency;

  modport source (output valid, func, load_index, load_value, frequency, input ready);
  modport sink (input valid, func, load_index, load_value, frequency, output ready);
endinterface

interface cisp_result_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] sample_out;
  logic        playing;

  modport source (output valid, sample_out, playing, input ready);
  modport sink (input valid, sample_out, playing, output ready);
endinterface

[hw/rtl/cisp_ctrl.sv]
// Sequencing state machine for load, trigger and tick items.
module cisp_ctrl #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         func,
  output logic               in_ready,
  input  cisp_pkg::status_t  status,
  output cisp_pkg::cmd_t     cmd
);

  localparam int CW = $clog2(STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVIDE, S_NBR, S_READ, S_COEF, S_MUL, S_ADD, S_FINISH, S_STOP
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    cmd.rd_sel  = cnt[1:0];
    cmd.cap_sel = 2'(cnt - CW'(1));
    cmd.add_sel = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = (func == cisp_pkg::FUNC_LOAD);
          cmd.trigger     = (func == cisp_pkg::FUNC_TRIGGER);
          cmd.div_init    = (func == cisp_pkg::FUNC_TICK) && status.active;
        end
      end
      S_DIVIDE: cmd.div_step = 1'b1;
      S_NBR:    cmd.nbr_calc = 1'b1;
      S_READ: begin
        cmd.rd_en  = (cnt < CW'(4));
        cmd.cap_en = (cnt != '0);
      end
      S_COEF:   cmd.coef = 1'b1;
      S_MUL:    cmd.mul = 1'b1;
      S_ADD:    cmd.acc_add = 1'b1;
      S_FINISH: cmd.finish = !status.out_full;
      S_STOP:   cmd.stop_tick = !status.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid && func == cisp_pkg::FUNC_TICK) begin
            state <= status.active ? S_DIVIDE : S_STOP;
          end
        end
        S_DIVIDE: begin
          if (cnt == CW'(STEPS - 1)) begin
            cnt   <= '0;
            state <= S_NBR;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_NBR: state <= S_READ;
        S_READ: begin
          if (cnt == CW'(4)) begin
            cnt   <= '0;
            state <= S_COEF;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_COEF: state <= S_MUL;
        S_MUL:  state <= S_ADD;
        S_ADD: begin
          if (cnt[1:0] == cisp_pkg::HSTEP_A3) begin
            state <= S_FINISH;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_MUL;
          end
        end
        S_FINISH: if (!status.out_full) state <= S_IDLE;
        S_STOP:   if (!status.out_full) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/cisp_datapath.sv]
// Sample store, divider, neighbour addressing, Horner evaluator and result register.
module cisp_datapath #(
  parameter int MAX_SAMPLES   = 65536,
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [15:0]        load_index,
  input  logic signed [23:0] load_value,
  input  logic [23:0]        frequency,
  input  cisp_pkg::cmd_t     cmd,
  output cisp_pkg::status_t  status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [23:0] sample_out,
  output logic               playing
);

  localparam int F     = FRACTION_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int IW    = $clog2(MAX_SAMPLES);
  localparam int LW    = IW + 1;
  localparam int INCW  = 8 + F;
  localparam int STEPS = (INCW > IW) ? INCW : IW;
  localparam int PW    = IW + F;
  localparam int SUMW  = ((IW > 8) ? IW : 8) + F + 1;
  localparam int AW    = S + 4;
  localparam int NW    = 24 + F;
  localparam int XW    = (LW > 17) ? LW : 17;
  localparam logic signed [S-1:0] SMAX = {1'b0, {(S - 1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S - 1){1'b0}}};

  logic              loop_en;
  logic [16:0]       sample_length;
  logic [23:0]       base_freq;
  logic [XW-1:0]     len_x;
  logic [LW-1:0]     len_eff;
  logic [IW-1:0]     len_m1;
  logic              len_nz;

  logic [PW-1:0]     pos;
  logic              is_playing;
  logic [IW-1:0]     idx;

  logic [S-1:0]      store [MAX_SAMPLES];
  logic              load_ok;
  logic [IW-1:0]     rd_addr;
  logic [S-1:0]      rd_data;

  logic [24:0]       div_rem;
  logic [STEPS-1:0]  div_bits;
  logic [STEPS-1:0]  div_q;
  logic              div_sat;
  logic [24:0]       div_trial;
  logic              div_ge;
  logic [NW-1:0]     num_full;
  logic [IW-1:0]     mod_rem;
  logic [STEPS-1:0]  mod_bits;
  logic [LW-1:0]     mod_trial;
  logic              mod_ge;
  logic [INCW-1:0]   inc;

  logic [IW-1:0]     nbr [4];
  logic [IW-1:0]     l0, l2, l3, c0, c1, c2, c3;
  logic [LW-1:0]     p1, p2;
  logic [IW+1:0]     e1, e2;

  logic signed [S-1:0]    y [4];
  logic signed [AW-1:0]   ys0, ys1, ys2, ys3, a0c;
  logic signed [AW-1:0]   a1, a2, a3, acc, a_sel;
  logic signed [F:0]      t_s;
  logic signed [AW+F:0]   prod;
  logic signed [AW+F:0]   prod_sh;
  logic signed [S-1:0]    sat_val;
  logic [SUMW-1:0]        pos_sum, pos_lim;
  logic                   wrap;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_en       <= 1'b0;
      sample_length <= '0;
      base_freq     <= 24'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cisp_pkg::CFG_LOOP:   loop_en <= cfg_data[0];
        cisp_pkg::CFG_LENGTH: sample_length <= cfg_data[16:0];
        cisp_pkg::CFG_BASE:   base_freq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_x   = XW'(sample_length);
  assign len_eff = (len_x > XW'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES) : LW'(len_x);
  assign len_m1  = IW'(len_eff - LW'(1));
  assign len_nz  = (len_eff != '0);
  assign idx     = pos[PW-1:F];

  // Sample store: one write port for loads, one registered read port for ticks.
  assign load_ok = (32'(load_index) < 32'(MAX_SAMPLES));

  always_comb begin
    unique case (cmd.rd_sel)
      cisp_pkg::NBR_PREV:  rd_addr = nbr[0];
      cisp_pkg::NBR_HERE:  rd_addr = nbr[1];
      cisp_pkg::NBR_NEXT:  rd_addr = nbr[2];
      cisp_pkg::NBR_AFTER: rd_addr = nbr[3];
      default:             rd_addr = nbr[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample && load_ok) begin
      store[IW'(load_index)] <= S'(load_value);
    end
    if (cmd.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // Restoring division for the increment and the wrapped index, run side by side.
  // Leading steps see zero quotient bits, so the shorter one is padded at the top.
  assign num_full  = {frequency, {F{1'b0}}};
  assign div_trial = {div_rem[23:0], div_bits[STEPS-1]};
  assign div_ge    = (div_trial >= {1'b0, base_freq});
  assign mod_trial = {mod_rem, mod_bits[STEPS-1]};
  assign mod_ge    = (mod_trial >= len_eff);
  assign inc       = div_sat ? {INCW{1'b1}} : div_q[INCW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem  <= 25'(num_full >> STEPS);
      div_bits <= num_full[STEPS-1:0];
      div_q    <= '0;
      div_sat  <= ({8'd0, frequency[23:8]} >= base_freq);
      mod_rem  <= '0;
      mod_bits <= STEPS'(idx);
    end else if (cmd.div_step) begin
      div_rem  <= div_ge ? (div_trial - {1'b0, base_freq}) : div_trial;
      div_bits <= div_bits << 1;
      div_q    <= {div_q[STEPS-2:0], div_ge};
      mod_rem  <= mod_ge ? IW'(mod_trial - len_eff) : IW'(mod_trial);
      mod_bits <= mod_bits << 1;
    end
  end

  // Neighbour addresses: wrapped round the length when looping, clamped otherwise.
  always_comb begin
    l0 = (mod_rem == '0) ? len_m1 : (mod_rem - IW'(1));
    p1 = {1'b0, mod_rem} + LW'(1);
    l2 = (p1 >= len_eff) ? '0 : IW'(p1);
    p2 = {1'b0, l2} + LW'(1);
    l3 = (p2 >= len_eff) ? '0 : IW'(p2);
    e1 = (IW + 2)'(idx) + (IW + 2)'(1);
    e2 = (IW + 2)'(idx) + (IW + 2)'(2);
    if (idx == '0) begin
      c0 = '0;
    end else begin
      c0 = ((idx - IW'(1)) > len_m1) ? len_m1 : (idx - IW'(1));
    end
    c1 = (idx > len_m1) ? len_m1 : idx;
    c2 = (e1 > (IW + 2)'(len_m1)) ? len_m1 : IW'(e1);
    c3 = (e2 > (IW + 2)'(len_m1)) ? len_m1 : IW'(e2);
  end

  always_ff @(posedge clk) begin
    if (cmd.nbr_calc) begin
      nbr[0] <= loop_en ? l0 : c0;
      nbr[1] <= loop_en ? mod_rem : c1;
      nbr[2] <= loop_en ? l2 : c2;
      nbr[3] <= loop_en ? l3 : c3;
    end
    if (cmd.cap_en) begin
      y[cmd.cap_sel] <= rd_data;
    end
  end

  // Horner evaluation with one registered multiply per step.
  assign ys0     = AW'(y[0]);
  assign ys1     = AW'(y[1]);
  assign ys2     = AW'(y[2]);
  assign ys3     = AW'(y[3]);
  assign a0c     = ys3 - ys2 - ys0 + ys1;
  assign t_s     = {1'b0, pos[F-1:0]};
  assign prod_sh = prod >>> F;

  always_comb begin
    unique case (cmd.add_sel)
      cisp_pkg::HSTEP_A1: a_sel = a1;
      cisp_pkg::HSTEP_A2: a_sel = a2;
      default:            a_sel = a3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      acc <= a0c;
      a1  <= ys0 - ys1 - a0c;
      a2  <= ys2 - ys0;
      a3  <= ys1;
    end else if (cmd.acc_add) begin
      acc <= AW'(prod_sh) + a_sel;
    end
    if (cmd.mul) begin
      prod <= acc * t_s;
    end
  end

  always_comb begin
    if (acc > AW'(SMAX)) begin
      sat_val = SMAX;
    end else if (acc < AW'(SMIN)) begin
      sat_val = SMIN;
    end else begin
      sat_val = S'(acc);
    end
  end

  assign pos_sum = SUMW'(pos) + SUMW'(inc);
  assign pos_lim = SUMW'({len_eff, {F{1'b0}}});
  assign wrap    = (pos_sum >= pos_lim);

  // Play position and play flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      is_playing <= 1'b0;
    end else if (cmd.trigger && len_nz) begin
      pos        <= '0;
      is_playing <= 1'b1;
    end else if (cmd.finish) begin
      pos <= wrap ? '0 : PW'(pos_sum);
      if (wrap && !loop_en) begin
        is_playing <= 1'b0;
      end
    end else if (cmd.stop_tick) begin
      is_playing <= 1'b0;
    end
  end

  // Result register; a new beat is loaded only once the previous one has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish || cmd.stop_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out <= 24'(sat_val);
      playing    <= !(wrap && !loop_en);
    end else if (cmd.stop_tick) begin
      sample_out <= '0;
      playing    <= 1'b0;
    end
  end

  assign status.active   = is_playing && len_nz;
  assign status.out_full = out_valid && !out_ready;

endmodule

[hw/rtl/cubic_interpolated_sample_player_top.sv]
// Top level of the cubic interpolated sample player.
// Usage: items arrive on the items channel (valid/ready); a beat is taken when both are high.
// A load beat writes one sample into the store, a trigger beat restarts playback at position
// zero when the length is nonzero, and a tick beat produces exactly one beat on the results
// channel. Registers are to be written by the user through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this. Loads and triggers are
// done in the idle state. A tick while playing runs the divider steps (one quotient bit a
// cycle, restoring divider; the wrapped index is found in the same pass), an addressing step,
// four reads through the single store read port, a coefficient step, three multiply-add steps
// and a result step; the next item can be taken in the cycle in which the result is shown. A
// tick while stopped passes through a stop step that loads a zero, not-playing result.
// One item is in flight at a time; items.ready is high whenever no tick is in progress.
// The result sits in an output register, so if the receiver stalls, loads, triggers and a new
// tick are still taken, and that tick waits at its final step until the register is free.
// Reset clears the play flag, position, result valid and registers (base frequency to 256);
// the sample store is not cleared and must be loaded before it is played.
module cubic_interpolated_sample_player_top #(
  parameter int MAX_SAMPLES   = 65536,
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data,
  cisp_item_if.sink     items,
  cisp_result_if.source results
);

  localparam int INCW  = 8 + FRACTION_BITS;
  localparam int IW    = $clog2(MAX_SAMPLES);
  localparam int STEPS = (INCW > IW) ? INCW : IW;

  cisp_pkg::cmd_t    cmd;
  cisp_pkg::status_t status;

  cisp_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .func     (items.func),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cisp_datapath #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load_index (items.load_index),
    .load_value (items.load_value),
    .frequency  (items.frequency),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .sample_out (results.sample_out),
    .playing    (results.playing)
  );

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_sample, cmd.trigger, cmd.div_init, cmd.div_step, cmd.nbr_calc,
              cmd.coef, cmd.mul, cmd.acc_add, cmd.finish, cmd.stop_tick}))
    else $error("more than one datapath phase commanded");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.stop_tick) |=> results.valid)
    else $error("finished tick did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.stop_tick) |-> !(results.valid && !results.ready))
    else $error("result register overwritten while stalled");

  a_busy_during_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.div_step || cmd.mul) |-> !items.ready)
    else $error("input accepted while a tick is in progress");

endmodule

[test/tb_cubic_interpolated_sample_player_top.sv]
// Self-checking testbench for the cubic interpolated sample player.
`timescale 1ns / 100ps

module tb_cubic_interpolated_sample_player_top;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] load_index;
    logic [23:0] load_value;
    logic [23:0] frequency;
  } item_t;

  typedef struct packed {
    logic [23:0] sample_out;
    logic        playing;
  } sound_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  cisp_item_if items ();
  cisp_result_if results ();

  cubic_interpolated_sample_player_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(items), .results(results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [23:0] pcm_store [0:65535];
  logic [63:0] play_pos;
  bit          play_on;
  bit          loop_on;
  logic [16:0] len_reg;
  logic [23:0] base_reg;

  item_t  pending_items [$];
  sound_t sounds_due [$];
  int     errors = 0;
  int     cycles = 0;
  bit     send_idle = 1'b0;
  bit     recv_idle = 1'b0;
  int     hold_off = 0;
  bit     no_idle = 1'b0;

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic longint floor_frac(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint neighbour(input longint j, input longint n);
    if (loop_on) begin
      j = j % n;
      if (j < 0) j += n;
    end else begin
      if (j < 0) j = 0;
      if (j > n - 1) j = n - 1;
    end
    return longint'(signed'(pcm_store[j[15:0]]));
  endfunction

  task automatic predict_sound(input item_t it);
    longint n, inc, i, t, y0, y1, y2, y3, a0, a1, a2, acc;
    sound_t s;
    n = (len_reg > 17'd65536) ? 65536 : longint'(len_reg);
    case (it.func)
      cisp_pkg::FUNC_LOAD: pcm_store[it.load_index] = it.load_value;
      cisp_pkg::FUNC_TRIGGER: if (n != 0) begin
        play_pos = 0;
        play_on = 1'b1;
      end
      cisp_pkg::FUNC_TICK: begin
        if (!play_on || n == 0) begin
          play_on = 1'b0;
          s = '0;
        end else begin
          if (base_reg == 0) inc = 64'hFFFFFF;
          else begin
            inc = (longint'(it.frequency) << 16) / longint'(base_reg);
            if (inc > 64'hFFFFFF) inc = 64'hFFFFFF;
          end
          i = longint'(play_pos >> 16);
          t = longint'(play_pos[15:0]);
          y0 = neighbour(i - 1, n);
          y1 = neighbour(i, n);
          y2 = neighbour(i + 1, n);
          y3 = neighbour(i + 2, n);
          a0 = y3 - y2 - y0 + y1;
          a1 = y0 - y1 - a0;
          a2 = y2 - y0;
          acc = floor_frac(a0 * t) + a1;
          acc = floor_frac(acc * t) + a2;
          acc = floor_frac(acc * t) + y1;
          if (acc > 8388607) acc = 8388607;
          if (acc < -8388608) acc = -8388608;
          play_pos += inc;
          if (play_pos >= (n << 16)) begin
            play_pos = 0;
            if (!loop_on) play_on = 1'b0;
          end
          s.sample_out = acc[23:0];
          s.playing = play_on;
        end
        sounds_due.push_back(s);
      end
      default: ;
    endcase
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
    end else begin
      if (items.valid && items.ready) begin
        predict_sound(item_t'({items.func, items.load_index, items.load_value,
                               items.frequency}));
        void'(pending_items.pop_front());
      end
      if (items.valid && !items.ready) begin
        // Offer held until taken.
      end else if (pending_items.size() > (items.valid && items.ready ? 0 : 0) &&
                   !send_idle && (no_idle || $urandom_range(99) >= 26)) begin
        items.valid <= 1'b1;
        {items.func, items.load_index, items.load_value, items.frequency} <= pending_items[0];
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  // Receiver hold-off counted here.
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Monitor.
  always @(posedge clk) begin
    sound_t want;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (sounds_due.size() == 0) begin
          report("unexpected result beat", results.sample_out, 24'd0);
        end else begin
          want = sounds_due.pop_front();
          if (results.sample_out !== want.sample_out)
            report("sample_out", results.sample_out, want.sample_out);
          if (results.playing !== want.playing)
            report("playing", {23'd0, results.playing}, {23'd0, want.playing});
        end
      end
      results.ready <= (hold_off == 0) && (no_idle || $urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    items.valid = 1'b0;
    items.func = '0;
    items.load_index = '0;
    items.load_value = '0;
    items.frequency = '0;
    results.ready = 1'b0;
  end

  // The driver has taken an item when its queue has shrunk.
  task automatic drain();
    while (pending_items.size() != 0 || items.valid) @(posedge clk);
    while (sounds_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cisp_pkg::CFG_LOOP: loop_on = val[0];
      cisp_pkg::CFG_LENGTH: len_reg = val[16:0];
      cisp_pkg::CFG_BASE: base_reg = val;
      default: ;
    endcase
  endtask

  function automatic item_t mk(input logic [1:0] f, input logic [15:0] a,
                               input logic [23:0] v, input logic [23:0] fr);
    return {f, a, v, fr};
  endfunction

  // Loads every entry below n so that no unwritten entry is ever read.
  task automatic fill(input int n);
    for (int k = 0; k < n; k++)
      pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, k[15:0], $urandom, $urandom));
  endtask

  function automatic logic [23:0] rand_freq();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 24'hFFFFFF;
      default: return $urandom_range(2048);
    endcase
  endfunction

  initial begin
    int n;
    play_pos = 0;
    play_on = 1'b0;
    loop_on = 1'b0;
    len_reg = '0;
    base_reg = 24'd256;
    for (int k = 0; k < 65536; k++) pcm_store[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty buffer, extremes, shortened length, index beyond 2.
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd256));
    pending_items.push_back(mk(cisp_pkg::FUNC_TRIGGER, 0, 0, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd256));
    pending_items.push_back(mk(2'd3, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF));
    pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, 0, 24'h7FFFFF, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, 1, 24'h800000, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, 2, 24'h7FFFFF, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, 3, 24'h800000, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, 16'hFFFF, 24'h123456, 0));
    drain();
    write_reg(cisp_pkg::CFG_LENGTH, 24'd4);
    write_reg(2'd3, 24'hFFFFFF);
    pending_items.push_back(mk(cisp_pkg::FUNC_TRIGGER, 0, 0, 0));
    for (int k = 0; k < 6; k++)
      pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd100));
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd100));
    drain();
    write_reg(cisp_pkg::CFG_LOOP, 24'd1);
    write_reg(cisp_pkg::CFG_BASE, 24'd0);
    pending_items.push_back(mk(cisp_pkg::FUNC_TRIGGER, 0, 0, 0));
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'h000001));
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'hFFFFFF));
    drain();
    write_reg(cisp_pkg::CFG_BASE, 24'hFFFFFF);
    write_reg(cisp_pkg::CFG_LENGTH, 24'd2);
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'hFFFFFF));
    pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd0));
    drain();

    // Random phases with a range of settings.
    for (int ph = 0; ph < 12; ph++) begin
      n = (ph % 4 == 0) ? 1 : $urandom_range(3, 24);
      write_reg(cisp_pkg::CFG_LOOP, $urandom_range(1));
      write_reg(cisp_pkg::CFG_BASE, (ph == 5) ? 24'd1 : (ph == 6) ? 24'hFFFFFF :
                                    24'd64 + $urandom_range(1024));
      write_reg(cisp_pkg::CFG_LENGTH, (ph == 7) ? 24'h1FFFF : n);
      no_idle = (ph == 3);
      if (ph == 7) fill(16);
      else fill(n);
      if (ph == 7) begin
        // The loads must have gone in before the length changes.
        drain();
        write_reg(cisp_pkg::CFG_LENGTH, 24'd16);
      end
      pending_items.push_back(mk(cisp_pkg::FUNC_TRIGGER, $urandom, $urandom, $urandom));
      for (int k = 0; k < 55; k++) begin
        case ($urandom_range(19))
          0: pending_items.push_back(mk(cisp_pkg::FUNC_TRIGGER, $urandom, $urandom,
                                        $urandom));
          1: pending_items.push_back(mk(2'd3, $urandom, $urandom, $urandom));
          2: pending_items.push_back(mk(cisp_pkg::FUNC_LOAD, $urandom_range(n - 1),
                                        $urandom, $urandom));
          default: pending_items.push_back(mk(cisp_pkg::FUNC_TICK, $urandom, $urandom,
                                              rand_freq()));
        endcase
        if (ph == 2 && k == 20) hold_off = 400;
      end
      if (ph == 9) begin
        // Sender pauses until every result is in, then carries on.
        while (pending_items.size() != 0 || items.valid) @(posedge clk);
        send_idle = 1'b1;
        while (sounds_due.size() != 0) @(posedge clk);
        send_idle = 1'b0;
        pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, rand_freq()));
      end
      drain();
      if (ph == 10) begin
        // Shorten the length under a running position.
        write_reg(cisp_pkg::CFG_LENGTH, 24'd2);
        pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd1));
        pending_items.push_back(mk(cisp_pkg::FUNC_TICK, 0, 0, 24'd1));
        drain();
      end
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
